/* hw/rtl/bilinear_grid_interpolator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear grid interpolator
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_INTERPOLATOR_TOP_MACROS_SVH
`define BILINEAR_GRID_INTERPOLATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define BGI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bgi assertion failed");
// condition must never be seen outside reset
`define BGI_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bgi assertion failed");
`else
`define BGI_ASSERT(lbl, prop)
`define BGI_NEVER(lbl, cond)
`endif

`endif

/* hw/rtl/bgi_pkg.sv */
// ----------------------------------------------------------------------------
// bgi_pkg
// Types and constants of the bilinear grid interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgi_pkg;

  // grid geometry
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int SIZE_W    = 7;

  // number formats
  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int FRACIN_W = FRAC_W + 1;
  localparam int XPOS_W   = FRAC_W + COL_W;
  localparam int YPOS_W   = FRAC_W + ROW_W;

  // 2x2 banking on row and column parity
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int ENTRY_W    = 2 * VAL_W;

  // stream widths
  localparam int IN_FIELDS_W = ROW_W + COL_W + 2 * VAL_W + 2 * FRACIN_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_TDATA_W = 2 * VAL_W;
  localparam int CFG_DATA_W  = SIZE_W;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_INTERP = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic [FRACIN_W-1:0] y_fraction;
    logic [FRACIN_W-1:0] x_fraction;
    logic [VAL_W-1:0]    lon_value;
    logic [VAL_W-1:0]    lat_value;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } in_beat_t;

  typedef logic signed [VAL_W-1:0]          val_t;
  typedef logic signed [VAL_W:0]            diff_t;
  typedef logic signed [VAL_W+FRAC_W+1:0]   prod_t;
  typedef logic        [FRAC_W-1:0]         frac_t;

endpackage

/* hw/rtl/bilinear_grid_interpolator_top.sv */
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_top
// Banked latitude/longitude grids with a pipelined bilinear lookup.
// ----------------------------------------------------------------------------
// Use:
//   in_*  : one beat per item. in_tuser selects a grid write or an
//           interpolation; in_tdata carries row, column, the two values and
//           the x and y positions (Q1.16, saturated at 1.0).
//   out_* : one beat per interpolation, latitude and longitude results.
//   cfg_* : rows_in_use (index 0) and cols_in_use (index 1), written idle.
// Throughput: one item per cycle while in_tready is high. The grids sit in
//   four banks split on row and column parity, so the four neighbours are
//   read together and a write can follow or precede a lookup in the next cycle.
// Pipeline: scale, bank read, horizontal multiply, horizontal rounding add,
//   vertical multiply, then the final rounding add into the result queue.
// Stall: results queue in an eight-entry buffer; in_tready drops only when
//   in-flight and queued lookups would fill it, so the input keeps running
//   while a result waits.
// Reset: grid sizes return to 64 by 64, pipeline and queue empty. Grid
//   contents are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bilinear_grid_interpolator_top_macros.svh"

module bilinear_grid_interpolator_top
  import bgi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row, col, lat_value, lon_value, x_fraction, y_fraction, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                   in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // lat_result, lon_result
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  localparam logic [FRACIN_W-1:0] FRAC_ONE = FRACIN_W'(1) << FRAC_W;
  localparam prod_t               HALF     = prod_t'(1) << (FRAC_W - 1);

  logic [ROW_W-1:0]  rows_m1_r, rows_m1_nxt;
  logic [COL_W-1:0]  cols_m1_r, cols_m1_nxt;

  in_beat_t          beat;
  kind_t             beat_kind;
  logic              in_acc;
  logic              out_pop;
  logic [FRACIN_W-1:0] xf_sat, yf_sat;

  // stage 1: scaled positions or pending write
  logic              s1_wr_r, s1_rd_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ENTRY_W-1:0] s1_entry_r;
  logic [XPOS_W-1:0] s1_xs_r;
  logic [YPOS_W-1:0] s1_ys_r;

  logic [ROW_W-1:0]  y0, y1;
  logic [COL_W-1:0]  x0, x1;
  logic [ROW_W-1:0]  row_sel [2];
  logic [COL_W-1:0]  col_sel [2];
  logic [BANK_AW-1:0] raddr [NUM_BANKS];
  logic [BANK_AW-1:0] waddr;
  logic [BANK_SEL_W-1:0] wbank;

  logic [ENTRY_W-1:0] grid_mem [NUM_BANKS][BANK_DEPTH];

  // stage 2: bank read data
  logic [ENTRY_W-1:0] rd_data_r [NUM_BANKS];
  logic              s2_v_r;
  logic [BANK_SEL_W-1:0] s2_bank_r [NUM_BANKS];
  frac_t             s2_dx_r, s2_dy_r;
  logic [ENTRY_W-1:0] nb [NUM_BANKS];
  val_t              nb_a, nb_b;
  diff_t             c_diff;

  // stage 3: horizontal products
  logic              s3_v_r;
  val_t              s3_a_r    [2][2];
  prod_t             s3_prod_r [2][2], s3_prod_nxt [2][2];
  frac_t             s3_dy_r;

  // stage 4: horizontal lerps
  logic              s4_v_r;
  val_t              s4_lerp_r [2][2], s4_lerp_nxt [2][2];
  frac_t             s4_dy_r;

  // stage 5: vertical products
  logic              res_v_r;
  val_t              s5_top_r  [2];
  prod_t             s5_prod_r [2], s5_prod_nxt [2];
  diff_t             e_diff;
  val_t              res_val   [2];

  // result queue
  logic [OUT_TDATA_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [FIFO_CW-1:0] occ_r, occ_nxt;

  // --------------------------------------------------------------------------
  // Size register: zero reads as one, above the grid saturates
  // --------------------------------------------------------------------------
  function automatic logic [SIZE_W-1:0] size_m1(input logic [SIZE_W-1:0] v,
                                                input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > lim) begin
      r = lim - SIZE_W'(1);
    end else begin
      r = v - SIZE_W'(1);
    end
    return r;
  endfunction

  // configuration decode
  always_comb begin
    rows_m1_nxt = rows_m1_r;
    cols_m1_nxt = cols_m1_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_m1_nxt = ROW_W'(size_m1(cfg_data, SIZE_W'(GRID_ROWS)));
        CFG_COLS: cols_m1_nxt = COL_W'(size_m1(cfg_data, SIZE_W'(GRID_COLS)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m1_r <= ROW_W'(GRID_ROWS - 1);
      cols_m1_r <= COL_W'(GRID_COLS - 1);
    end else begin
      rows_m1_r <= rows_m1_nxt;
      cols_m1_r <= cols_m1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input beat: saturate positions and scale by size minus one
  // --------------------------------------------------------------------------
  assign beat      = in_beat_t'(in_tdata);
  assign beat_kind = kind_t'(in_tuser);
  assign in_tready = (occ_r != FIFO_CW'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign out_pop   = out_tvalid && out_tready;

  assign xf_sat = (beat.x_fraction > FRAC_ONE) ? FRAC_ONE : beat.x_fraction;
  assign yf_sat = (beat.y_fraction > FRAC_ONE) ? FRAC_ONE : beat.y_fraction;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_wr_r <= 1'b0;
      s1_rd_r <= 1'b0;
    end else begin
      s1_wr_r <= in_acc && (beat_kind == KIND_WRITE) &&
                 (beat.row <= rows_m1_r) && (beat.col <= cols_m1_r);
      s1_rd_r <= in_acc && (beat_kind == KIND_INTERP);
    end
  end

  always_ff @(posedge clk) begin
    s1_row_r   <= beat.row;
    s1_col_r   <= beat.col;
    s1_entry_r <= {beat.lon_value, beat.lat_value};
    s1_xs_r    <= XPOS_W'(xf_sat) * XPOS_W'(cols_m1_r);
    s1_ys_r    <= YPOS_W'(yf_sat) * YPOS_W'(rows_m1_r);
  end

  // --------------------------------------------------------------------------
  // Index split, edge clamp and bank addresses
  // --------------------------------------------------------------------------
  assign y0 = s1_ys_r[YPOS_W-1:FRAC_W];
  assign x0 = s1_xs_r[XPOS_W-1:FRAC_W];
  assign y1 = (y0 < rows_m1_r) ? y0 + ROW_W'(1) : rows_m1_r;
  assign x1 = (x0 < cols_m1_r) ? x0 + COL_W'(1) : cols_m1_r;

  // even / odd row and column of the neighbour pair
  assign row_sel[0] = y0[0] ? y1 : y0;
  assign row_sel[1] = y0[0] ? y0 : y1;
  assign col_sel[0] = x0[0] ? x1 : x0;
  assign col_sel[1] = x0[0] ? x0 : x1;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      raddr[b] = {row_sel[b / 2][ROW_W-1:1], col_sel[b % 2][COL_W-1:1]};
    end
  end

  assign waddr = {s1_row_r[ROW_W-1:1], s1_col_r[COL_W-1:1]};
  assign wbank = {s1_row_r[0], s1_col_r[0]};

  // --------------------------------------------------------------------------
  // Grid banks: writes and reads meet here in beat order, so a lookup
  // right after a write already sees it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (s1_wr_r && (wbank == BANK_SEL_W'(b))) begin
        grid_mem[b][waddr] <= s1_entry_r;
      end
      rd_data_r[b] <= grid_mem[b][raddr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_rd_r;
    end
  end

  // neighbour order: top-left, top-right, bottom-left, bottom-right
  always_ff @(posedge clk) begin
    s2_bank_r[0] <= {y0[0], x0[0]};
    s2_bank_r[1] <= {y0[0], x1[0]};
    s2_bank_r[2] <= {y1[0], x0[0]};
    s2_bank_r[3] <= {y1[0], x1[0]};
    s2_dx_r      <= s1_xs_r[FRAC_W-1:0];
    s2_dy_r      <= s1_ys_r[FRAC_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Horizontal products: (b - a) * dx for both rows of both grids
  // --------------------------------------------------------------------------
  always_comb begin
    nb_a   = '0;
    nb_b   = '0;
    c_diff = '0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      nb[k] = rd_data_r[s2_bank_r[k]];
    end
    for (int g = 0; g < 2; g++) begin
      for (int r = 0; r < 2; r++) begin
        nb_a   = val_t'(nb[2 * r][g * VAL_W +: VAL_W]);
        nb_b   = val_t'(nb[2 * r + 1][g * VAL_W +: VAL_W]);
        c_diff = diff_t'(nb_b) - diff_t'(nb_a);
        s3_prod_nxt[g][r] = prod_t'(c_diff) * prod_t'({1'b0, s2_dx_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      for (int r = 0; r < 2; r++) begin
        s3_a_r[g][r]    <= val_t'(nb[2 * r][g * VAL_W +: VAL_W]);
        s3_prod_r[g][r] <= s3_prod_nxt[g][r];
      end
    end
    s3_dy_r <= s2_dy_r;
  end

  // --------------------------------------------------------------------------
  // Horizontal lerp: a plus rounded product, ties toward plus infinity
  // --------------------------------------------------------------------------
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      for (int r = 0; r < 2; r++) begin
        s4_lerp_nxt[g][r] = s3_a_r[g][r] +
                            val_t'((s3_prod_r[g][r] + HALF) >>> FRAC_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_lerp_r <= s4_lerp_nxt;
    s4_dy_r   <= s3_dy_r;
  end

  // --------------------------------------------------------------------------
  // Vertical products: (bottom - top) * dy
  // --------------------------------------------------------------------------
  always_comb begin
    e_diff = '0;
    for (int g = 0; g < 2; g++) begin
      e_diff         = diff_t'(s4_lerp_r[g][1]) - diff_t'(s4_lerp_r[g][0]);
      s5_prod_nxt[g] = prod_t'(e_diff) * prod_t'({1'b0, s4_dy_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      s5_top_r[g]  <= s4_lerp_r[g][0];
      s5_prod_r[g] <= s5_prod_nxt[g];
    end
  end

  // final rounding add
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      res_val[g] = s5_top_r[g] + val_t'((s5_prod_r[g] + HALF) >>> FRAC_W);
    end
  end

  // --------------------------------------------------------------------------
  // Result queue; occupancy counts every lookup from acceptance to pop
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (res_v_r) begin
      fifo_mem[wr_ptr_r] <= {res_val[1], res_val[0]};
    end
  end

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r + FIFO_CW'(res_v_r) - FIFO_CW'(out_pop);
    occ_nxt      = occ_r + FIFO_CW'(in_acc && (beat_kind == KIND_INTERP))
                   - FIFO_CW'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (res_v_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_nxt;
      occ_r      <= occ_nxt;
    end
  end

  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = fifo_mem[rd_ptr_r];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BGI_NEVER(a_fifo_overflow, res_v_r && (fifo_cnt_r == FIFO_CW'(FIFO_DEPTH)) && !out_pop)
  `BGI_ASSERT(a_queue_within_occ, fifo_cnt_r <= occ_r)
  `BGI_ASSERT(a_idle_is_empty, (occ_r == FIFO_CW'(0)) |-> (!out_tvalid && !s1_rd_r && !s2_v_r && !s3_v_r && !s4_v_r && !res_v_r))
  `BGI_ASSERT(a_write_from_beat, s1_wr_r |-> $past(in_tvalid && in_tready))

endmodule
